FILE: sv/bpa_pkg.sv
// Shared types, constants and codes of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int AddrW = 40;
  localparam int WordW = 64;
  localparam int BitW = 6;

  localparam int NumPagesDef = 4096;
  localparam int PageShiftBitsDef = 12;

  localparam logic [AddrW-1:0] RegionBaseRst = 40'd4194304;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

FILE: sv/bpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bpa_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/bpa_ffz.sv
// Find-first-zero over one word of the used map.
`default_nettype none

module bpa_ffz (
  input  wire logic [bpa_pkg::WordW-1:0] word_i,
  output logic                           found_o,
  output logic      [bpa_pkg::BitW-1:0]  index_o
);

  import bpa_pkg::*;

  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    // Walk downwards so that the lowest free bit wins.
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        found_o = 1'b1;
        index_o = BitW'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bitmap_page_allocator.sv
// Top level of the first-fit bitmap page allocator.
// Each item is taken when start is high and busy is low, and its one result appears on
// done_o for a single cycle; the receiver cannot stall it, and busy drops in the cycle that
// shows the result. The used map lives in a RAM of 64-bit rows, one row read per cycle. An
// allocation scans rows from the lowest upwards until it finds a free bit, whose page address
// it then forms, or has checked the last row; a free checks its address, then reads and
// rewrites its row, and ends after the check when the address falls outside the managed range.
// A single 41-bit adder is shared between the address check of a free and the address
// calculation of an allocation. After reset the map is cleared one row a cycle, and busy stays
// high until every row is cleared; configuration writes are accepted at any time.
`default_nettype none

module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NumPagesDef,
  parameter int PAGE_SHIFT_BITS = bpa_pkg::PageShiftBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       opcode_i,
  input  wire logic [bpa_pkg::AddrW-1:0]  free_address_i,
  output logic                            done_o,
  output logic      [1:0]                 status_o,
  output logic      [bpa_pkg::AddrW-1:0]  page_address_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [bpa_pkg::AddrW-1:0]  cfg_data_i
);

  import bpa_pkg::*;

  localparam int NumWords = (NUM_PAGES + WordW - 1) / WordW;
  localparam int RowW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int IdxW = RowW + BitW;
  localparam int LastBits = NUM_PAGES - (NumWords - 1) * WordW;
  localparam logic [RowW-1:0] LastRow = RowW'(NumWords - 1);
  // Bits past the last page of the final row always read as used.
  localparam logic [WordW-1:0] PadMask =
      (LastBits == WordW) ? '0 : ~((64'd1 << LastBits) - 64'd1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_ADDR  = 6'b001000,
    S_FCHK  = 6'b010000,
    S_FWR   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] faddr_q, faddr_d;
  logic [RowW-1:0]  cnt_q, cnt_d;
  logic             chk_v_q, chk_v_d;
  logic [RowW-1:0]  chk_row_q, chk_row_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic [AddrW-1:0] paddr_q, paddr_d;

  // Shared adder: a - b for the free range check, a + b for the allocated address.
  logic             add_sub;
  logic [AddrW-1:0] add_a, add_b;
  logic [AddrW:0]   add_sum;

  logic [AddrW-1:0] off_idx;
  logic             out_range;

  logic             ram_we, ram_re;
  logic [RowW-1:0]  ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  logic [WordW-1:0] scan_word;
  logic             ffz_found;
  logic [BitW-1:0]  ffz_index;

  logic             accept;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {AddrW{add_sub}}} + (AddrW + 1)'(add_sub);

  // On a free the carry out is set when the address is not below the base.
  assign off_idx = add_sum[AddrW-1:0] >> PAGE_SHIFT_BITS;
  assign out_range = !add_sum[AddrW] || (off_idx >= AddrW'(NUM_PAGES));

  assign scan_word = ram_rdata | ((chk_row_q == LastRow) ? PadMask : '0);

  bpa_ffz u_ffz (
    .word_i (scan_word),
    .found_o(ffz_found),
    .index_o(ffz_index)
  );

  bpa_ram #(
    .Width(WordW),
    .Depth(NumWords),
    .AddrW(RowW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    faddr_d   = faddr_q;
    cnt_d     = cnt_q;
    chk_v_d   = chk_v_q;
    chk_row_d = chk_row_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    status_d  = status_q;
    paddr_d   = paddr_q;

    add_sub = 1'b1;
    add_a   = faddr_q;
    add_b   = base_q;

    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cnt_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LastRow) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          chk_v_d = 1'b0;
          faddr_d = free_address_i;
          state_d = (opcode_i == OP_FREE) ? S_FCHK : S_SCAN;
        end
      end

      S_SCAN: begin
        // Reads are issued one row ahead of the row being checked.
        ram_re    = 1'b1;
        chk_v_d   = 1'b1;
        chk_row_d = cnt_q;
        if (cnt_q != LastRow) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (chk_v_q) begin
          if (ffz_found) begin
            ram_we    = 1'b1;
            ram_waddr = chk_row_q;
            ram_wdata = ram_rdata | (WordW'(1) << ffz_index);
            idx_d     = {chk_row_q, ffz_index};
            state_d   = S_ADDR;
          end else if (chk_row_q == LastRow) begin
            done_d   = 1'b1;
            status_d = ST_NOMEM;
            paddr_d  = '0;
            state_d  = S_IDLE;
          end
        end
      end

      S_ADDR: begin
        add_sub  = 1'b0;
        add_a    = base_q;
        add_b    = AddrW'(idx_q) << PAGE_SHIFT_BITS;
        done_d   = 1'b1;
        status_d = ST_OK;
        paddr_d  = add_sum[AddrW-1:0];
        state_d  = S_IDLE;
      end

      S_FCHK: begin
        idx_d = off_idx[IdxW-1:0];
        if (out_range) begin
          done_d   = 1'b1;
          status_d = ST_RANGE;
          paddr_d  = '0;
          state_d  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = off_idx[BitW +: RowW];
          state_d   = S_FWR;
        end
      end

      S_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[BitW +: RowW];
        ram_wdata = ram_rdata & ~(WordW'(1) << idx_q[BitW-1:0]);
        done_d    = 1'b1;
        status_d  = ST_OK;
        paddr_d   = '0;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      base_q   <= RegionBaseRst;
      cnt_q    <= '0;
      chk_v_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      paddr_q  <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      chk_v_q  <= chk_v_d;
      done_q   <= done_d;
      status_q <= status_d;
      paddr_q  <= paddr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    faddr_q   <= faddr_d;
    chk_row_q <= chk_row_d;
    idx_q     <= idx_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign page_address_o = paddr_q;

endmodule

`default_nettype wire
